@@ rtl/core/sdssr_pkg.sv @@
package sdssr_pkg;

  // display geometry
  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned RESULT_CAP = 8;
  localparam int unsigned DIGIT_CAP  = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;

  // binary to bcd conversion
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned SHIFT_CW   = $clog2(MAG_W);
  localparam logic [3:0]  DABBLE_LIMIT = 4'd5;
  localparam logic [3:0]  DABBLE_ADD   = 4'd3;

  // configuration port
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_DIGITS_IN_USE = 1'b0;
  localparam logic [3:0] DIGITS_IN_USE_RESET = 4'd8;

  // segment bits, a in bit 0 through g in bit 6
  localparam logic [6:0] SEG_A = 7'h01;
  localparam logic [6:0] SEG_B = 7'h02;
  localparam logic [6:0] SEG_C = 7'h04;
  localparam logic [6:0] SEG_D = 7'h08;
  localparam logic [6:0] SEG_E = 7'h10;
  localparam logic [6:0] SEG_F = 7'h20;
  localparam logic [6:0] SEG_G = 7'h40;
  localparam logic [6:0] GLYPH_MINUS = SEG_G;

  typedef struct packed {
    logic signed [31:0] number;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               align_left;
  } in_t;

  typedef struct packed {
    logic [2:0] digit_index;
    logic [6:0] segments;
    logic [7:0] seg_red;
    logic [7:0] seg_green;
    logic [7:0] seg_blue;
    logic       last;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  function automatic logic [6:0] digit_glyph(input logic [3:0] d);
    logic [6:0] g;
    case (d)
      4'd0:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1:    g = SEG_B | SEG_C;
      4'd2:    g = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
      4'd3:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
      4'd4:    g = SEG_F | SEG_G | SEG_B | SEG_C;
      4'd5:    g = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
      4'd6:    g = SEG_A | SEG_F | SEG_E | SEG_D | SEG_C | SEG_G;
      4'd7:    g = SEG_A | SEG_B | SEG_C;
      4'd8:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd9:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/core/sdssr_bcd_conv.sv @@
module sdssr_bcd_conv (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sdssr_pkg::MAG_W-1:0]      mag,
  output sdssr_pkg::conv_stat_t            stat,
  output logic [sdssr_pkg::BCD_W-1:0]      bcd
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [sdssr_pkg::SHIFT_CW-1:0]    cnt_r, cnt_nxt;
  logic [sdssr_pkg::MAG_W-1:0]       bin_r, bin_nxt;
  logic [sdssr_pkg::BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [sdssr_pkg::BCD_W-1:0]       adj;

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < sdssr_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= sdssr_pkg::DABBLE_LIMIT) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + sdssr_pkg::DABBLE_ADD;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      bin_nxt  = mag;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bin_nxt = {bin_r[sdssr_pkg::MAG_W-2:0], 1'b0};
      bcd_nxt = {adj[sdssr_pkg::BCD_W-2:0], bin_r[sdssr_pkg::MAG_W-1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sdssr_pkg::SHIFT_CW'(sdssr_pkg::MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

@@ rtl/core/signed_decimal_seven_segment_render.sv @@
// signed decimal seven-segment renderer: each request carries a signed 32-bit number, an rgb
// color and an alignment flag, and produces one result per digit position in use (register
// digits_in_use at address 0, reset 8, capped at 8), in ascending position order, with last
// set on the final one. a negative number gets a minus sign (segment g) in front of its
// magnitude; text is right-aligned unless align_left is set, and text longer than the display
// is clipped at its tail. blank positions give zero segments and zero color. one request is
// handled at a time and in_stall stays high until its final result has been loaded into the
// output register (or, with no positions in use, until setup ends). a request goes through
// accept, the shift-and-add-3 bcd converter (one magnitude bit per cycle), load, a scan that
// strips leading zero digits one at a time, setup, and then one result per digit position in
// use; output stall holds the emit phase.
module signed_decimal_seven_segment_render (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sdssr_pkg::in_t                  in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output sdssr_pkg::out_t                 out_data,
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sdssr_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [sdssr_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [sdssr_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                            cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_PREP,
    ST_EMIT
  } state_t;

  state_t                           state_r, state_nxt;

  // configuration
  logic [3:0]                       diu_r, diu_nxt;
  logic [sdssr_pkg::REG_IDX_W-1:0]  cfg_idx;
  logic                             cfg_wr;

  // captured request
  logic                             neg_r, neg_nxt;
  logic                             left_r, left_nxt;
  logic [7:0]                       red_r, red_nxt;
  logic [7:0]                       green_r, green_nxt;
  logic [7:0]                       blue_r, blue_nxt;

  // digit string, most significant digit at the top
  logic [sdssr_pkg::BCD_W-1:0]      norm_r, norm_nxt;
  logic [3:0]                       nd_r, nd_nxt;
  logic [3:0]                       total_r, total_nxt;

  // emit control
  logic [3:0]                       count_r, count_nxt;
  logic [3:0]                       start_r, start_nxt;
  logic [3:0]                       rem_r, rem_nxt;
  logic [3:0]                       d_r, d_nxt;
  logic                             minus_r, minus_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  sdssr_pkg::out_t                  out_r, out_nxt;

  // converter
  logic                             accept;
  logic [sdssr_pkg::MAG_W-1:0]      raw;
  logic [sdssr_pkg::MAG_W-1:0]      mag;
  sdssr_pkg::conv_stat_t            conv_stat;
  logic [sdssr_pkg::BCD_W-1:0]      conv_bcd;

  // emit helpers
  logic                             load;
  logic                             lit;
  logic                             is_last;
  logic [3:0]                       top_digit;
  logic [3:0]                       count_cap;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // magnitude as an unsigned value, so the most negative number works too
  assign raw = in_data.number;
  assign mag = raw[sdssr_pkg::MAG_W-1] ? (sdssr_pkg::MAG_W'(0) - raw) : raw;

  sdssr_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .mag   (mag),
    .stat  (conv_stat),
    .bcd   (conv_bcd)
  );

  // apb register access, index taken from the word address
  assign cfg_idx    = cfg_paddr[sdssr_pkg::CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == sdssr_pkg::REG_DIGITS_IN_USE) ?
                      sdssr_pkg::CFG_DW'(diu_r) : '0;

  // count of positions driven, capped by the display and result capacity
  assign count_cap = (diu_r > 4'(sdssr_pkg::DIGIT_CAP)) ? 4'(sdssr_pkg::DIGIT_CAP) : diu_r;

  assign top_digit = norm_r[sdssr_pkg::BCD_W-1 -: 4];
  assign load      = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign lit       = (d_r >= start_r) && (rem_r != 4'd0);
  assign is_last   = (d_r == count_r - 4'd1);

  always_comb begin
    state_nxt     = state_r;
    diu_nxt       = diu_r;
    neg_nxt       = neg_r;
    left_nxt      = left_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    norm_nxt      = norm_r;
    nd_nxt        = nd_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    start_nxt     = start_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    minus_nxt     = minus_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    if (cfg_wr && (cfg_idx == sdssr_pkg::REG_DIGITS_IN_USE)) begin
      diu_nxt = cfg_pwdata[3:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt   = in_data.number[sdssr_pkg::MAG_W-1];
          left_nxt  = in_data.align_left;
          red_nxt   = in_data.red;
          green_nxt = in_data.green;
          blue_nxt  = in_data.blue;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_stat.done) begin
          norm_nxt  = conv_bcd;
          nd_nxt    = 4'(sdssr_pkg::BCD_DIGITS);
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // strip leading zeros, keeping at least one digit
        if ((top_digit == 4'd0) && (nd_r > 4'd1)) begin
          norm_nxt = {norm_r[sdssr_pkg::BCD_W-5:0], 4'd0};
          nd_nxt   = nd_r - 4'd1;
        end else begin
          total_nxt = nd_r + 4'(neg_r);
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        count_nxt = count_cap;
        rem_nxt   = total_r;
        minus_nxt = neg_r;
        d_nxt     = 4'd0;
        if (left_r || (total_r >= count_cap)) begin
          start_nxt = 4'd0;
        end else begin
          start_nxt = count_cap - total_r;
        end
        state_nxt = (count_cap == 4'd0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt       = 1'b1;
          out_nxt.digit_index = d_r[2:0];
          out_nxt.last        = is_last;
          if (lit) begin
            out_nxt.segments  = minus_r ? sdssr_pkg::GLYPH_MINUS :
                                sdssr_pkg::digit_glyph(top_digit);
            out_nxt.seg_red   = red_r;
            out_nxt.seg_green = green_r;
            out_nxt.seg_blue  = blue_r;
            rem_nxt           = rem_r - 4'd1;
            if (minus_r) begin
              minus_nxt = 1'b0;
            end else begin
              norm_nxt = {norm_r[sdssr_pkg::BCD_W-5:0], 4'd0};
            end
          end else begin
            out_nxt.segments  = 7'h00;
            out_nxt.seg_red   = 8'h00;
            out_nxt.seg_green = 8'h00;
            out_nxt.seg_blue  = 8'h00;
          end
          d_nxt = d_r + 4'd1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      diu_r       <= sdssr_pkg::DIGITS_IN_USE_RESET;
      out_valid_r <= 1'b0;
      count_r     <= 4'd0;
      start_r     <= 4'd0;
      rem_r       <= 4'd0;
      d_r         <= 4'd0;
      minus_r     <= 1'b0;
      nd_r        <= 4'd0;
      total_r     <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      diu_r       <= diu_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      rem_r       <= rem_nxt;
      d_r         <= d_nxt;
      minus_r     <= minus_nxt;
      nd_r        <= nd_nxt;
      total_r     <= total_nxt;
    end
    neg_r   <= neg_nxt;
    left_r  <= left_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    norm_r  <= norm_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // the converter only runs while the sequencer waits on it
  a_conv_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (conv_stat.busy || conv_stat.done) |-> (state_r == ST_CONV))
    else $error("converter active outside conversion phase");

  // emit position stays inside the digits in use
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (d_r < count_r))
    else $error("emit position beyond digits in use");

  // loading the final result frees the block for the next request
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && is_last) |=> ((state_r == ST_IDLE) && out_valid_r && out_r.last))
    else $error("final result did not return the block to idle");

  // digit count stays between one and the number of bcd digits while stripping zeros
  a_norm_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NORM) |-> ((nd_r >= 4'd1) && (nd_r <= 4'(sdssr_pkg::BCD_DIGITS))))
    else $error("digit count out of range");
`endif

endmodule

@@ bench/digit_result_checker.sv @@
`timescale 1ns / 1ps

module digit_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  sdssr_pkg::in_t                in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sdssr_pkg::out_t               out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sdssr_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [sdssr_pkg::CFG_DW-1:0]  cfg_pwdata,
  input  logic                          cfg_pready,
  output int unsigned                   pending,
  output int unsigned                   failures
);

  localparam int unsigned DEC_RADIX = 10;
  localparam int unsigned MAX_CHARS = 11;

  logic [3:0]       digits_in_use = sdssr_pkg::DIGITS_IN_USE_RESET;
  sdssr_pkg::out_t  expected_digits [$];
  sdssr_pkg::out_t  want_digit;
  int unsigned      error_count = 0;

  assign failures = error_count;

  // glyphs for decimal digits zero through nine
  function automatic logic [6:0] digit_shape(input int unsigned d);
    logic [6:0] s;
    case (d)
      0: s = sdssr_pkg::SEG_A | sdssr_pkg::SEG_B | sdssr_pkg::SEG_C | sdssr_pkg::SEG_D |
             sdssr_pkg::SEG_E | sdssr_pkg::SEG_F;
      1: s = sdssr_pkg::SEG_B | sdssr_pkg::SEG_C;
      2: s = sdssr_pkg::SEG_A | sdssr_pkg::SEG_B | sdssr_pkg::SEG_D | sdssr_pkg::SEG_E |
             sdssr_pkg::SEG_G;
      3: s = sdssr_pkg::SEG_A | sdssr_pkg::SEG_B | sdssr_pkg::SEG_C | sdssr_pkg::SEG_D |
             sdssr_pkg::SEG_G;
      4: s = sdssr_pkg::SEG_B | sdssr_pkg::SEG_C | sdssr_pkg::SEG_F | sdssr_pkg::SEG_G;
      5: s = sdssr_pkg::SEG_A | sdssr_pkg::SEG_C | sdssr_pkg::SEG_D | sdssr_pkg::SEG_F |
             sdssr_pkg::SEG_G;
      6: s = sdssr_pkg::SEG_A | sdssr_pkg::SEG_C | sdssr_pkg::SEG_D | sdssr_pkg::SEG_E |
             sdssr_pkg::SEG_F | sdssr_pkg::SEG_G;
      7: s = sdssr_pkg::SEG_A | sdssr_pkg::SEG_B | sdssr_pkg::SEG_C;
      8: s = sdssr_pkg::SEG_A | sdssr_pkg::SEG_B | sdssr_pkg::SEG_C | sdssr_pkg::SEG_D |
             sdssr_pkg::SEG_E | sdssr_pkg::SEG_F | sdssr_pkg::SEG_G;
      9: s = sdssr_pkg::SEG_A | sdssr_pkg::SEG_B | sdssr_pkg::SEG_C | sdssr_pkg::SEG_D |
             sdssr_pkg::SEG_F | sdssr_pkg::SEG_G;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // builds the glyph string and queues one result per digit position
  function automatic void render_number(input sdssr_pkg::in_t req);
    logic [31:0]      mag;
    logic [6:0]       rev [DEC_RADIX];
    logic [6:0]       chars [MAX_CHARS];
    int               n_rev;
    int               n_chars;
    int               count;
    int               first;
    int               ci;
    bit               lit;
    sdssr_pkg::out_t  res;
    mag = req.number;
    if (req.number[31]) mag = 32'd0 - mag;
    n_rev = 0;
    do begin
      rev[n_rev] = digit_shape(mag % DEC_RADIX);
      n_rev++;
      mag = mag / DEC_RADIX;
    end while (mag != 0 && n_rev < DEC_RADIX);
    n_chars = 0;
    if (req.number[31]) begin
      chars[n_chars] = sdssr_pkg::GLYPH_MINUS;
      n_chars++;
    end
    for (int i = n_rev - 1; i >= 0; i--) begin
      chars[n_chars] = rev[i];
      n_chars++;
    end
    count = (digits_in_use > sdssr_pkg::DIGIT_CAP) ? int'(sdssr_pkg::DIGIT_CAP) :
            int'(digits_in_use);
    first = 0;
    if (!req.align_left) begin
      first = count - n_chars;
      if (first < 0) first = 0;
    end
    for (int pos = 0; pos < count; pos++) begin
      ci = pos - first;
      lit = (ci >= 0) && (ci < n_chars);
      res.digit_index = 3'(pos);
      res.segments    = lit ? chars[ci] : 7'h00;
      res.seg_red     = lit ? req.red : 8'h00;
      res.seg_green   = lit ? req.green : 8'h00;
      res.seg_blue    = lit ? req.blue : 8'h00;
      res.last        = (pos == count - 1);
      expected_digits.push_back(res);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      digits_in_use = sdssr_pkg::DIGITS_IN_USE_RESET;
      expected_digits.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[sdssr_pkg::CFG_AW-1:2] == sdssr_pkg::REG_DIGITS_IN_USE)
        digits_in_use = cfg_pwdata[3:0];
      if (in_valid && !in_stall) render_number(in_data);
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit result, expected none actual %h", $time, out_data);
          error_count++;
        end else begin
          want_digit = expected_digits.pop_front();
          check_field("digit_index", want_digit.digit_index, out_data.digit_index);
          check_field("segments", want_digit.segments, out_data.segments);
          check_field("seg_red", want_digit.seg_red, out_data.seg_red);
          check_field("seg_green", want_digit.seg_green, out_data.seg_green);
          check_field("seg_blue", want_digit.seg_blue, out_data.seg_blue);
          check_field("last", want_digit.last, out_data.last);
        end
      end
    end
    pending <= expected_digits.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned IDLE_PERCENT   = 8;
  localparam int unsigned HOLD_CYCLES    = 400;
  // settling time that covers one request in flight
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 28;
  localparam int unsigned N_PHASES       = 11;
  localparam int unsigned HOLD_PHASE     = 0;
  localparam int unsigned QUIET_PHASE    = 3;
  localparam int unsigned PAUSE_PHASE    = 6;

  // register addresses, plus one that decodes to no register
  localparam logic [sdssr_pkg::CFG_AW-1:0] ADDR_DIGITS = {sdssr_pkg::REG_DIGITS_IN_USE, 2'b00};
  localparam logic [sdssr_pkg::CFG_AW-1:0] ADDR_SPARE  = {~sdssr_pkg::REG_DIGITS_IN_USE, 2'b00};

  logic                          clk;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  sdssr_pkg::in_t                in_data     = '0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  sdssr_pkg::out_t               out_data;
  logic                          cfg_psel    = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite  = 1'b0;
  logic [sdssr_pkg::CFG_AW-1:0]  cfg_paddr   = '0;
  logic [sdssr_pkg::CFG_DW-1:0]  cfg_pwdata  = '0;
  logic [sdssr_pkg::CFG_DW-1:0]  cfg_prdata;
  logic                          cfg_pready;

  int unsigned pending;
  int unsigned failures;

  // receiver control: one long hold-off and a stretch with no idling
  logic        hold_trigger = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  logic        quiet        = 1'b0;
  int unsigned idle_cycles  = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  signed_decimal_seven_segment_render dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  digit_result_checker results_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .pending     (pending),
    .failures    (failures)
  );

  // result side: long hold-off once when asked, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_trigger && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // digit counts for the random phases, extremes and out-of-range included
  function automatic logic [3:0] phase_digits(input int unsigned p);
    logic [3:0] n;
    case (p)
      0:       n = 4'd8;
      1:       n = 4'd3;
      2:       n = 4'd1;
      3:       n = 4'd6;
      4:       n = 4'd0;
      5:       n = 4'd15;
      6:       n = 4'd5;
      7:       n = 4'd2;
      8:       n = 4'd7;
      9:       n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic sdssr_pkg::in_t make_request(input logic signed [31:0] number,
                                                  input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b, input logic left);
    sdssr_pkg::in_t req;
    req.number     = number;
    req.red        = r;
    req.green      = g;
    req.blue       = b;
    req.align_left = left;
    return req;
  endfunction

  // mostly a random decimal length so every text width is hit, some raw words
  function automatic sdssr_pkg::in_t random_request();
    int unsigned    n_digits;
    longint         lo;
    longint         hi;
    logic [31:0]    mag;
    n_digits = $urandom_range(1, 10);
    lo = 1;
    repeat (n_digits - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    mag = 32'(lo + ($urandom % (hi - lo + 1)));
    if ($urandom_range(0, 1)) mag = 32'd0 - mag;
    if ($urandom_range(0, 4) == 0) mag = $urandom;
    return make_request(mag, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  // offer one request, with an occasional gap in front, and wait for it to be taken
  task automatic send_request(input sdssr_pkg::in_t req);
    if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // all results in, then let a request with no results finish too
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [sdssr_pkg::CFG_AW-1:0] addr,
                                input logic [sdssr_pkg::CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // register changes only with the block idle
  task automatic set_digits(input logic [3:0] count);
    in_valid <= 1'b0;
    wait_drained();
    write_register(ADDR_DIGITS, sdssr_pkg::CFG_DW'(count));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset digit count: zero, small, exact fit, clipped, extreme magnitudes
    send_request(make_request(0, 8'hff, 8'hff, 8'hff, 1'b1));
    send_request(make_request(0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_request(make_request(1, 8'hff, 8'h00, 8'hff, 1'b0));
    send_request(make_request(-1, 8'h00, 8'hff, 8'h00, 1'b1));
    send_request(make_request(7, 8'ha5, 8'h5a, 8'h3c, 1'b0));
    send_request(make_request(12345678, 8'h12, 8'h34, 8'h56, 1'b0));
    send_request(make_request(-1234567, 8'h80, 8'h01, 8'h7f, 1'b1));
    // ten digits on eight positions: tail clipped for either alignment
    send_request(make_request(2147483647, 8'hff, 8'hff, 8'hff, 1'b0));
    send_request(make_request(-2147483647, 8'h01, 8'h02, 8'h04, 1'b1));
    // most negative word: minus sign then the unsigned magnitude, clipped at its tail
    send_request(make_request(32'h8000_0000, 8'hc3, 8'h3c, 8'h99, 1'b0));
    send_request(make_request(99999999, 8'h66, 8'h99, 8'h00, 1'b1));
    send_request(make_request(-10000000, 8'h0f, 8'hf0, 8'h55, 1'b0));

    // single position: minus shown alone when the text overflows
    set_digits(4'd1);
    send_request(make_request(5, 8'h11, 8'h22, 8'h33, 1'b1));
    send_request(make_request(-3, 8'h44, 8'h55, 8'h66, 1'b0));
    send_request(make_request(42, 8'h77, 8'h88, 8'h99, 1'b0));

    // zero positions: requests taken but nothing comes out
    set_digits(4'd0);
    send_request(make_request(7, 8'haa, 8'hbb, 8'hcc, 1'b0));
    send_request(make_request(-7, 8'hdd, 8'hee, 8'hff, 1'b1));

    // above the digit cap: treated as eight positions
    set_digits(4'd15);
    send_request(make_request(-123, 8'h10, 8'h20, 8'h30, 1'b0));
    send_request(make_request(4567, 8'h40, 8'h50, 8'h60, 1'b1));

    // write to the unused address must leave the digit count alone
    in_valid <= 1'b0;
    wait_drained();
    write_register(ADDR_SPARE, sdssr_pkg::CFG_DW'(2));
    send_request(make_request(89, 8'h70, 8'h80, 8'h90, 1'b0));

    // random phases over a spread of digit counts
    for (int p = 0; p < N_PHASES; p++) begin
      set_digits(phase_digits(p));
      quiet <= (p == QUIET_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver holds off while the sender keeps offering, filling the block
        if (p == HOLD_PHASE && i == 10) hold_trigger <= 1'b1;
        // sender stops until every queued result has been delivered
        if (p == PAUSE_PHASE && i == 15) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_request(random_request());
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
